// File: hdl/cct_pkg.sv
// cct_pkg: shared constants and width helpers for the circumcircle unit
// no dependencies
`default_nettype none
package cct_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int OUT_WIDTH       = 32;
  localparam int SQ_WIDTH        = 64;
  localparam int QUEUE_DEPTH     = 4;

  // numerator width of the center quotients
  function automatic int num_width(input int w);
    return 3 * w + 4;
  endfunction

  // determinant width
  function automatic int det_width(input int w);
    return 2 * w + 3;
  endfunction

  // one queue entry: two numerators, determinant, four coordinates
  function automatic int q_width(input int w);
    return 2 * num_width(w) + det_width(w) + 4 * w;
  endfunction

endpackage
`default_nettype wire

// File: hdl/cct_if.sv
// cct_in_if / cct_out_if: valid-ready channels of the circumcircle unit
// no dependencies
`default_nettype none
interface cct_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] p1_x;
  logic signed [W-1:0] p1_y;
  logic signed [W-1:0] p2_x;
  logic signed [W-1:0] p2_y;
  logic signed [W-1:0] p3_x;
  logic signed [W-1:0] p3_y;
  modport source (output valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, input ready);
  modport sink   (input valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, output ready);
endinterface

interface cct_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic        [31:0] radius;
  logic               degenerate;
  logic               saturated;
  modport source (output valid, center_x, center_y, radius, degenerate, saturated,
                  input ready);
  modport sink   (input valid, center_x, center_y, radius, degenerate, saturated,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/cct_front.sv
// cct_front: chord differences, determinant and Cramer numerators, 5 stages
// depends on cct_pkg, cct_if
`default_nettype none
module cct_front #(
  parameter int W = cct_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  cct_in_if.sink                                  pts,
  output logic                                    q_valid,
  input  wire logic                               q_full,
  output logic [cct_pkg::q_width(W)-1:0]          q_data
);
  import cct_pkg::*;

  localparam int AW  = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int DW  = det_width(W);
  localparam int TW3 = 3 * W + 3;
  localparam int NW  = num_width(W);

  logic [5:1] v;
  logic       adv;

  logic signed [AW-1:0] a1_1, b1_1, a2_1, b2_1;
  logic signed [AW-1:0] a1_2, b1_2, a2_2, b2_2;
  logic signed [AW-1:0] a1_3, b1_3, a2_3, b2_3;
  logic signed [PW-1:0] m_a1b2, m_a2b1, sq_a1, sq_b1, sq_a2, sq_b2;
  logic signed [DW-1:0] d_3, d_4, d_5;
  logic signed [PW-1:0] s1_3, s2_3;
  logic signed [TW3-1:0] t1, t2, t3, t4;
  logic signed [NW-1:0] nx, ny;
  logic [4*W-1:0] c_1, c_2, c_3, c_4, c_5;

  assign adv       = !(v[5] && q_full);
  assign pts.ready = adv;
  assign q_valid   = v[5];
  assign q_data    = {nx, ny, d_5, c_5};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[4:1], pts.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_1 <= AW'(pts.p1_x) - AW'(pts.p2_x);
      b1_1 <= AW'(pts.p1_y) - AW'(pts.p2_y);
      a2_1 <= AW'(pts.p3_x) - AW'(pts.p2_x);
      b2_1 <= AW'(pts.p3_y) - AW'(pts.p2_y);
      c_1  <= {pts.p1_x, pts.p1_y, pts.p2_x, pts.p2_y};

      m_a1b2 <= a1_1 * b2_1;
      m_a2b1 <= a2_1 * b1_1;
      sq_a1  <= a1_1 * a1_1;
      sq_b1  <= b1_1 * b1_1;
      sq_a2  <= a2_1 * a2_1;
      sq_b2  <= b2_1 * b2_1;
      a1_2 <= a1_1;
      b1_2 <= b1_1;
      a2_2 <= a2_1;
      b2_2 <= b2_1;
      c_2  <= c_1;

      d_3  <= DW'(m_a1b2) - DW'(m_a2b1);
      s1_3 <= sq_a1 + sq_b1;
      s2_3 <= sq_a2 + sq_b2;
      a1_3 <= a1_2;
      b1_3 <= b1_2;
      a2_3 <= a2_2;
      b2_3 <= b2_2;
      c_3  <= c_2;

      t1  <= s1_3 * b2_3;
      t2  <= s2_3 * b1_3;
      t3  <= a1_3 * s2_3;
      t4  <= a2_3 * s1_3;
      d_4 <= d_3;
      c_4 <= c_3;

      nx  <= NW'(t1) - NW'(t2);
      ny  <= NW'(t3) - NW'(t4);
      d_5 <= d_4;
      c_5 <= c_4;
    end
  end

endmodule
`default_nettype wire

// File: hdl/cct_queue.sv
// cct_queue: small register queue between front and back
// depends on cct_pkg
`default_nettype none
module cct_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = cct_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_full,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);
  import cct_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wp, rp;
  logic [CW-1:0]     cnt;
  logic              push, pop;

  assign push_full = (cnt == CW'(DEPTH));
  assign pop_valid = (cnt != '0);
  assign push      = push_valid && !push_full;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hdl/cct_div.sv
// cct_div: pipelined rounding divider, two numerators over one shared divisor
// one quotient bit per stage; depends on cct_pkg
`default_nettype none
module cct_div #(
  parameter int NW = 52,
  parameter int DW = 35,
  parameter int TW = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire logic                 in_v,
  input  wire logic signed [NW-1:0] nx,
  input  wire logic signed [NW-1:0] ny,
  input  wire logic signed [DW-1:0] d,
  input  wire logic [TW-1:0]        tag_in,
  output logic                      out_v,
  output logic signed [NW+1:0]      qx,
  output logic signed [NW+1:0]      qy,
  output logic [TW-1:0]             tag_out
);
  import cct_pkg::*;

  localparam int NB = NW + 1;
  localparam int MW = DW + 1;

  logic [NB:0] v;

  logic [MW-1:0] m   [0:NB];
  logic [MW-1:0] rx  [0:NB];
  logic [MW-1:0] ry  [0:NB];
  logic [NB-1:0] nrx [0:NB];
  logic [NB-1:0] nry [0:NB];
  logic [NB-1:0] qxr [0:NB];
  logic [NB-1:0] qyr [0:NB];
  logic          sx  [0:NB];
  logic          sy  [0:NB];
  logic [TW-1:0] tg  [0:NB];

  logic [DW-1:0] ad;
  logic [NW-1:0] anx, any;

  assign ad  = d[DW-1]  ? DW'(-d)  : DW'(d);
  assign anx = nx[NW-1] ? NW'(-nx) : NW'(nx);
  assign any = ny[NW-1] ? NW'(-ny) : NW'(ny);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NB-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m[0]   <= {ad, 1'b0};
      rx[0]  <= '0;
      ry[0]  <= '0;
      nrx[0] <= {1'b0, anx} + NB'(ad);
      nry[0] <= {1'b0, any} + NB'(ad);
      qxr[0] <= '0;
      qyr[0] <= '0;
      sx[0]  <= nx[NW-1] ^ d[DW-1];
      sy[0]  <= ny[NW-1] ^ d[DW-1];
      tg[0]  <= tag_in;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [MW:0] shx, shy;
    logic        gex, gey;
    assign shx = {rx[k], nrx[k][NB-1]};
    assign shy = {ry[k], nry[k][NB-1]};
    assign gex = (shx >= {1'b0, m[k]});
    assign gey = (shy >= {1'b0, m[k]});
    always_ff @(posedge clk) begin
      if (adv) begin
        m[k+1]   <= m[k];
        rx[k+1]  <= gex ? MW'(shx - {1'b0, m[k]}) : shx[MW-1:0];
        ry[k+1]  <= gey ? MW'(shy - {1'b0, m[k]}) : shy[MW-1:0];
        nrx[k+1] <= {nrx[k][NB-2:0], 1'b0};
        nry[k+1] <= {nry[k][NB-2:0], 1'b0};
        qxr[k+1] <= {qxr[k][NB-2:0], gex};
        qyr[k+1] <= {qyr[k][NB-2:0], gey};
        sx[k+1]  <= sx[k];
        sy[k+1]  <= sy[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign out_v   = v[NB];
  assign tag_out = tg[NB];
  assign qx = sx[NB] ? -$signed({1'b0, qxr[NB]}) : $signed({1'b0, qxr[NB]});
  assign qy = sy[NB] ? -$signed({1'b0, qyr[NB]}) : $signed({1'b0, qyr[NB]});

endmodule
`default_nettype wire

// File: hdl/cct_sqrt.sv
// cct_sqrt: pipelined integer square root, one result bit per stage
// depends on cct_pkg
`default_nettype none
module cct_sqrt #(
  parameter int SW = cct_pkg::SQ_WIDTH,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_v,
  input  wire logic [SW-1:0] s_in,
  input  wire logic [TW-1:0] tag_in,
  output logic               out_v,
  output logic [SW-1:0]      s_out,
  output logic [SW-1:0]      r_out,
  output logic [TW-1:0]      tag_out
);
  import cct_pkg::*;

  localparam int NS = SW / 2;

  logic [NS:0]   v;
  logic [SW-1:0] s  [0:NS];
  logic [SW-1:0] r  [0:NS];
  logic [TW-1:0] tg [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NS-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s[0]  <= s_in;
      r[0]  <= '0;
      tg[0] <= tag_in;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [SW-1:0] BIT = {{(SW-1){1'b0}}, 1'b1} << (SW - 2 - 2 * k);
    logic [SW-1:0] t;
    assign t = r[k] + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (s[k] >= t) begin
          s[k+1] <= s[k] - t;
          r[k+1] <= (r[k] >> 1) + BIT;
        end else begin
          s[k+1] <= s[k];
          r[k+1] <= r[k] >> 1;
        end
        tg[k+1] <= tg[k];
      end
    end
  end

  assign out_v   = v[NS];
  assign s_out   = s[NS];
  assign r_out   = r[NS];
  assign tag_out = tg[NS];

endmodule
`default_nettype wire

// File: hdl/cct_back.sv
// cct_back: divide, center, clip, squared distance, square root, output beat
// depends on cct_pkg, cct_if, cct_div, cct_sqrt
`default_nettype none
module cct_back #(
  parameter int W = cct_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire logic [cct_pkg::q_width(W)-1:0] q_data,
  cct_out_if.source                          circ
);
  import cct_pkg::*;

  localparam int NW  = num_width(W);
  localparam int DW  = det_width(W);
  localparam int NB  = NW + 1;
  localparam int XW  = (NB + 3 > 34) ? NB + 3 : 34;
  localparam int DTW = 4 * W + 1;
  localparam int STW = 2 * OUT_WIDTH + 3 + 2 * W;
  localparam logic signed [XW-1:0] CMAX = XW'(64'sh7FFF_FFFF);
  localparam logic signed [XW-1:0] CMIN = XW'(-64'sh8000_0000);
  localparam logic [XW-1:0]        RMAX = XW'(64'hFFFF_FFFF);

  logic adv;
  assign adv   = !circ.valid || circ.ready;
  assign q_pop = adv;

  logic [NW-1:0] nx_u, ny_u;
  logic [DW-1:0] d_u;
  logic [4*W-1:0] c_u;
  assign {nx_u, ny_u, d_u, c_u} = q_data;

  logic                 dv_out;
  logic signed [NW+1:0] qx, qy;
  logic [DTW-1:0]       dtag;

  cct_div #(.NW(NW), .DW(DW), .TW(DTW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_v    (q_valid),
    .nx      ($signed(nx_u)),
    .ny      ($signed(ny_u)),
    .d       ($signed(d_u)),
    .tag_in  ({c_u, (d_u == '0)}),
    .out_v   (dv_out),
    .qx      (qx),
    .qy      (qy),
    .tag_out (dtag)
  );

  logic signed [W-1:0] dx1, dy1, dx2, dy2;
  assign {dx1, dy1, dx2, dy2} = dtag[DTW-1:1];

  logic [4:1] v;

  // center
  logic signed [XW-1:0] cx, cy;
  logic signed [W-1:0]  x1_1, y1_1, x1_2, y1_2, x1_3, y1_3, x1_4, y1_4;
  logic                 dg_1, dg_2, dg_3, dg_4;

  // clip and distance
  logic signed [XW-1:0] ddx, ddy;
  logic [XW-1:0]        adx, ady;
  assign ddx = cx - XW'(x1_1);
  assign ddy = cy - XW'(y1_1);
  assign adx = ddx[XW-1] ? XW'(-ddx) : XW'(ddx);
  assign ady = ddy[XW-1] ? XW'(-ddy) : XW'(ddy);

  logic [OUT_WIDTH-1:0] cxo_2, cyo_2, cxo_3, cyo_3, cxo_4, cyo_4;
  logic                 satc_2, satc_3, satc_4;
  logic                 big_2, big_3, big_4;
  logic [31:0]          ax_2, ay_2;
  logic [63:0]          sqx_3, sqy_3;
  logic [SQ_WIDTH-1:0]  s_4;
  logic [SQ_WIDTH:0]    sum3;
  assign sum3 = {1'b0, sqx_3} + {1'b0, sqy_3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[3:1], dv_out};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx   <= XW'(dx2) + XW'(qx);
      cy   <= XW'(dy2) + XW'(qy);
      x1_1 <= dx1;
      y1_1 <= dy1;
      dg_1 <= dtag[0];

      cxo_2  <= (cx > CMAX) ? 32'h7FFF_FFFF : (cx < CMIN) ? 32'h8000_0000 : cx[31:0];
      cyo_2  <= (cy > CMAX) ? 32'h7FFF_FFFF : (cy < CMIN) ? 32'h8000_0000 : cy[31:0];
      satc_2 <= (cx > CMAX) || (cx < CMIN) || (cy > CMAX) || (cy < CMIN);
      big_2  <= (adx > RMAX) || (ady > RMAX);
      ax_2   <= adx[31:0];
      ay_2   <= ady[31:0];
      x1_2   <= x1_1;
      y1_2   <= y1_1;
      dg_2   <= dg_1;

      sqx_3  <= ax_2 * ax_2;
      sqy_3  <= ay_2 * ay_2;
      cxo_3  <= cxo_2;
      cyo_3  <= cyo_2;
      satc_3 <= satc_2;
      big_3  <= big_2;
      x1_3   <= x1_2;
      y1_3   <= y1_2;
      dg_3   <= dg_2;

      s_4    <= sum3[SQ_WIDTH-1:0];
      big_4  <= big_3 || sum3[SQ_WIDTH];
      cxo_4  <= cxo_3;
      cyo_4  <= cyo_3;
      satc_4 <= satc_3;
      x1_4   <= x1_3;
      y1_4   <= y1_3;
      dg_4   <= dg_3;
    end
  end

  logic                 sv_out;
  logic [SQ_WIDTH-1:0]  s_rem, r_root;
  logic [STW-1:0]       stag;

  cct_sqrt #(.SW(SQ_WIDTH), .TW(STW)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_v    (v[4]),
    .s_in    (s_4),
    .tag_in  ({cxo_4, cyo_4, satc_4, big_4, dg_4, x1_4, y1_4}),
    .out_v   (sv_out),
    .s_out   (s_rem),
    .r_out   (r_root),
    .tag_out (stag)
  );

  logic [OUT_WIDTH-1:0] f_cx, f_cy;
  logic                 f_satc, f_big, f_dg;
  logic signed [W-1:0]  f_x1, f_y1;
  logic [32:0]          r_rnd;
  logic                 r_sat;
  assign {f_cx, f_cy, f_satc, f_big, f_dg, f_x1, f_y1} = stag;
  assign r_rnd = r_root[32:0] + 33'((s_rem > r_root) ? 1 : 0);
  assign r_sat = f_big || r_rnd[32] || (r_root[SQ_WIDTH-1:33] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      circ.valid <= 1'b0;
    end else if (adv) begin
      circ.valid <= sv_out;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (f_dg) begin
        circ.center_x   <= 32'(f_x1);
        circ.center_y   <= 32'(f_y1);
        circ.radius     <= '0;
        circ.degenerate <= 1'b1;
        circ.saturated  <= 1'b0;
      end else begin
        circ.center_x   <= $signed(f_cx);
        circ.center_y   <= $signed(f_cy);
        circ.radius     <= r_sat ? 32'hFFFF_FFFF : r_rnd[31:0];
        circ.degenerate <= 1'b0;
        circ.saturated  <= f_satc || r_sat;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/circumcircle_three_points_unit.sv
// circumcircle_three_points_unit: center and radius of the circle through three points
// depends on cct_pkg, cct_if, cct_front, cct_queue, cct_back
//
//   channel | dir | beat
//   pts     | in  | p1_x p1_y p2_x p2_y p3_x p3_y (COORD_WIDTH each, signed)
//   circ    | out | center_x center_y radius degenerate saturated
//
// one beat per cycle sustained while circ is ready; pipeline depth is set mostly
// by the one-bit-per-stage divider and square root
// front stalls only when the queue is full, back only when circ is held
// synchronous reset clears valids and queue pointers, no clearing pass
`default_nettype none
module circumcircle_three_points_unit #(
  parameter int COORD_WIDTH = cct_pkg::COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  cct_in_if.sink    pts,
  cct_out_if.source circ
);
  import cct_pkg::*;

  localparam int QW = q_width(COORD_WIDTH);

  logic          f_valid, f_full, b_valid, b_pop;
  logic [QW-1:0] f_data, b_data;

  cct_front #(.W(COORD_WIDTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .pts     (pts),
    .q_valid (f_valid),
    .q_full  (f_full),
    .q_data  (f_data)
  );

  cct_queue #(.DATA_W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_full  (f_full),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_pop),
    .pop_data   (b_data)
  );

  cct_back #(.W(COORD_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_pop   (b_pop),
    .q_data  (b_data),
    .circ    (circ)
  );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for circumcircle_three_points_unit
// depends on cct_pkg, cct_if and the unit; predicts each circle exactly and
// compares every output beat against the oldest prediction
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  typedef struct packed {
    logic signed [15:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
  } tri_t;

  typedef struct packed {
    logic signed [31:0] center_x, center_y;
    logic        [31:0] radius;
    logic               degenerate, saturated;
  } circle_t;

  localparam int LATENCY   = 3 * 16 + 50;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cct_in_if #(.W(16)) pts ();
  cct_out_if circ ();

  circumcircle_three_points_unit #(.COORD_WIDTH(16)) uut (
    .clk(clk), .rst(rst), .pts(pts.sink), .circ(circ.source)
  );

  tri_t    pending_pts[$];
  circle_t expected_circles[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      hold_on = 1'b0;
  event    hold_go;
  int      quiet_cycles = 0;
  bit      stim_done = 1'b0;

  // rounded a / (2b), ties away from zero
  function automatic logic signed [127:0] round_half_div(
      input logic signed [127:0] a, input logic signed [127:0] b);
    logic signed [127:0] an, bn, q;
    an = a < 0 ? -a : a;
    bn = b < 0 ? -b : b;
    q = (an + bn) / (2 * bn);
    return ((a < 0) != (b < 0)) ? -q : q;
  endfunction

  function automatic logic [31:0] clip32(input logic signed [127:0] v, inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic circle_t circle_of(input tri_t t);
    logic signed [127:0] x1, y1, x2, y2, x3, y3, a1, b1, a2, b2, det, s1, s2, cx, cy;
    logic signed [127:0] dx, dy;
    logic [127:0] sq, root, rem, bitv;
    circle_t c;
    bit sat;
    x1 = t.p1_x; y1 = t.p1_y; x2 = t.p2_x; y2 = t.p2_y; x3 = t.p3_x; y3 = t.p3_y;
    a1 = x1 - x2; b1 = y1 - y2; a2 = x3 - x2; b2 = y3 - y2;
    det = a1 * b2 - a2 * b1;
    sat = 1'b0;
    c = '0;
    if (det == 0) begin
      c.center_x = x1[31:0];
      c.center_y = y1[31:0];
      c.degenerate = 1'b1;
      return c;
    end
    s1 = a1 * a1 + b1 * b1;
    s2 = a2 * a2 + b2 * b2;
    cx = x2 + round_half_div(s1 * b2 - s2 * b1, det);
    cy = y2 + round_half_div(a1 * s2 - a2 * s1, det);
    dx = cx - x1;
    dy = cy - y1;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx > 128'sd4294967295 || dy > 128'sd4294967295 ||
        dx * dx + dy * dy >= 128'h1_0000_0000_0000_0000) begin
      sat = 1'b1;
      c.radius = 32'hffffffff;
    end else begin
      sq = dx * dx + dy * dy;
      rem = sq;
      root = 0;
      bitv = 128'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - root - bitv;
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      if (rem > root) root = root + 1;
      if (root > 128'hffffffff) begin
        sat = 1'b1;
        c.radius = 32'hffffffff;
      end else begin
        c.radius = root[31:0];
      end
    end
    c.center_x = clip32(cx, sat);
    c.center_y = clip32(cy, sat);
    c.saturated = sat;
    return c;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_pts(input logic [15:0] a, b, c, d, e, f);
    tri_t t;
    t = {a, b, c, d, e, f};
    pending_pts.insert(pending_pts.size(), t);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // long receiver hold, counted here
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk);
    hold_on <= 1'b0;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pts.valid <= 1'b0;
      {pts.p1_x, pts.p1_y, pts.p2_x, pts.p2_y, pts.p3_x, pts.p3_y} <= '0;
    end else if (!pts.valid || pts.ready) begin
      if (pts.valid) expected_circles.insert(expected_circles.size(),
          circle_of({pts.p1_x, pts.p1_y, pts.p2_x, pts.p2_y, pts.p3_x, pts.p3_y}));
      if (pending_pts.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        {pts.p1_x, pts.p1_y, pts.p2_x, pts.p2_y, pts.p3_x, pts.p3_y} <=
          pending_pts.pop_front();
        pts.valid <= 1'b1;
      end else begin
        pts.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    circle_t want;
    if (rst) begin
      circ.ready <= 1'b0;
    end else begin
      if (circ.valid && circ.ready) begin
        if (expected_circles.size() == 0) begin
          $error("unexpected beat center_x=%0d", circ.center_x);
          errors++;
        end else begin
          want = expected_circles.pop_front();
          if (circ.center_x !== want.center_x) begin
            $error("center_x expected %0d got %0d", want.center_x, circ.center_x);
            errors++;
          end
          if (circ.center_y !== want.center_y) begin
            $error("center_y expected %0d got %0d", want.center_y, circ.center_y);
            errors++;
          end
          if (circ.radius !== want.radius) begin
            $error("radius expected %0d got %0d", want.radius, circ.radius);
            errors++;
          end
          if (circ.degenerate !== want.degenerate) begin
            $error("degenerate expected %0b got %0b", want.degenerate, circ.degenerate);
            errors++;
          end
          if (circ.saturated !== want.saturated) begin
            $error("saturated expected %0b got %0b", want.saturated, circ.saturated);
            errors++;
          end
        end
      end
      if (hold_on) begin
        circ.ready <= 1'b0;
      end else begin
        circ.ready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (pts.valid && pts.ready) || (circ.valid && circ.ready)) begin
      quiet_cycles <= 0;
    end else if (!hold_on) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT && !stim_done) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic wait_drain();
    int guard;
    guard = 0;
    while ((pending_pts.size() > 0 || pts.valid || expected_circles.size() > 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    int phase;
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed
    queue_pts(16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0000, 16'h0010);
    queue_pts(16'h0005, 16'h0005, 16'h0005, 16'h0005, 16'h0005, 16'h0005);
    queue_pts(16'h0000, 16'h0000, 16'h0010, 16'h0010, 16'h0020, 16'h0020);
    queue_pts(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
    queue_pts(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    queue_pts(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'hffff, 16'h0001);
    queue_pts(16'h8000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0001);
    queue_pts(16'h8000, 16'h8000, 16'h7fff, 16'h7ffe, 16'h7fff, 16'h7fff);
    queue_pts(16'h0000, 16'h0000, 16'h0003, 16'h0000, 16'h0000, 16'h0003);
    queue_pts(16'hffff, 16'hffff, 16'h0001, 16'hffff, 16'hffff, 16'h0001);
    queue_pts(16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h0100, 16'h0200);
    queue_pts(16'h0000, 16'h0000, 16'h0002, 16'h0000, 16'h0001, 16'h0001);
    wait_drain();

    // long receiver hold while the sender keeps offering
    -> hold_go;
    for (int i = 0; i < 150; i++)
      queue_pts(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord());
    wait_drain();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 21 : (phase == 1 ? 64 : 0);
      recv_idle_pct = phase == 0 ? 64 : (phase == 1 ? 21 : 0);
      for (n = 0; n < 180; n++) begin
        if ($urandom_range(0, 9) == 0)
          queue_pts(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());
        else begin
          logic [15:0] ax, ay, bx, by;
          ax = rand_coord();
          ay = rand_coord();
          bx = 16'($signed(ax) + $signed(16'($urandom_range(0, 8)) - 16'sd4));
          by = 16'($signed(ay) + $signed(16'($urandom_range(0, 8)) - 16'sd4));
          if ($urandom_range(0, 7) == 0)
            queue_pts(ax, ay, bx, by, ax, ay);
          else
            queue_pts(ax, ay, rand_coord(), rand_coord(), bx, by);
        end
      end
      wait_drain();
    end

    stim_done = 1'b1;
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_circles.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hdl/cct_pkg.sv
hdl/cct_if.sv
hdl/cct_front.sv
hdl/cct_queue.sv
hdl/cct_div.sv
hdl/cct_sqrt.sv
hdl/cct_back.sv
hdl/circumcircle_three_points_unit.sv
tb/sv/tb_top.sv
